// ===== design/tcc_pkg.sv =====
package tcc_pkg;

    // Default store geometry
    localparam int TCC_MAX_COLS = 128;
    localparam int TCC_MAX_ROWS = 64;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;
    localparam int COLOR_W = 8;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLS_W  = 8;
    localparam int ROWS_W  = 7;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GOTO  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 2'd2;

    // Register reset values
    localparam logic [COLS_W-1:0]  COLS_RESET  = 8'd80;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 7'd30;
    localparam logic [COLOR_W-1:0] COLOR_BLANK = 8'h07;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT = 8'h7f;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_RETURN     = 8'h0d;

    // One store cell
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
    } tcc_cell_t;

    localparam tcc_cell_t CELL_BLANK = '{ch: CHAR_SPACE, color: COLOR_BLANK};

endpackage

// ===== design/tcc_cmd_if.sv =====
interface tcc_cmd_if;
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;

    modport source (output valid, func, char_code, pos_x, pos_y, input ready);
    modport sink   (input valid, func, char_code, pos_x, pos_y, output ready);
endinterface

// ===== design/tcc_rsp_if.sv =====
interface tcc_rsp_if;
    import tcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [OCOL_W-1:0]  cursor_column;
    logic [OROW_W-1:0]  cursor_row;
    logic               scrolled;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;

    modport source (output valid, cursor_column, cursor_row, scrolled, cell_char, cell_color,
                    input ready);
    modport sink   (input valid, cursor_column, cursor_row, scrolled, cell_char, cell_color,
                    output ready);
endinterface

// ===== design/tcc_cfg_if.sv =====
interface tcc_cfg_if;
    import tcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/text_console_cursor_engine_top.sv =====
// Channel  Dir  Word                                                Accepted when
// cmd      in   func, char_code, pos_x, pos_y                        cmd.valid & cmd.ready
// rsp      out  cursor_column, cursor_row, scrolled, cell_char/color rsp.valid & rsp.ready
// cfg      in   index, data                                          cfg.valid & cfg.ready
//
// Put, goto and control codes pass through the finish state; read adds a wait state for the registered store read.
// Scroll walks the store with one cell copy per cycle, rows * MAX_COLS cells in all.
// Clear writes every cell of the store once.
// Reset returns cursor, control state and registers to reset values; the store holds garbage until the first clear.
// The result sits in an output register; a stalled rsp holds the next result in the finish state.
module text_console_cursor_engine_top #(
    parameter int MAX_COLS = tcc_pkg::TCC_MAX_COLS,
    parameter int MAX_ROWS = tcc_pkg::TCC_MAX_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    tcc_cmd_if.sink   cmd,
    tcc_rsp_if.source rsp,
    tcc_cfg_if.sink   cfg
);
    import tcc_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int ECW = $clog2(MAX_COLS + 1);
    localparam int ERW = $clog2(MAX_ROWS + 1);

    logic [COLS_W-1:0]  cols_reg, cols_next;
    logic [ROWS_W-1:0]  rows_reg, rows_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [ECW-1:0]     eff_cols;
    logic [ERW-1:0]     eff_rows;
    logic               color_reset;
    logic               mem_we;
    logic [CW+RW-1:0]   mem_waddr, mem_raddr;
    tcc_cell_t          mem_wcell, mem_rcell;

    assign cfg.ready = 1'b1;

    // Register writes; clear forces the color back to default
    always_comb
    begin
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        color_next = color_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COLUMNS: cols_next  = cfg.data;
                REG_ROWS:    rows_next  = cfg.data[ROWS_W-1:0];
                REG_COLOR:   color_next = cfg.data;
                default:     ;
            endcase
        end
        if (color_reset)
            color_next = COLOR_BLANK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= COLS_RESET;
            rows_reg  <= ROWS_RESET;
            color_reg <= COLOR_BLANK;
        end
        else
        begin
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            color_reg <= color_next;
        end
    end

    // Effective geometry: zero means one, saturate at store size
    always_comb
    begin
        if (cols_reg == '0)
            eff_cols = ECW'(1);
        else if (int'(cols_reg) > MAX_COLS)
            eff_cols = ECW'(MAX_COLS);
        else
            eff_cols = ECW'(cols_reg);

        if (rows_reg == '0)
            eff_rows = ERW'(1);
        else if (int'(rows_reg) > MAX_ROWS)
            eff_rows = ERW'(MAX_ROWS);
        else
            eff_rows = ERW'(rows_reg);
    end

    tcc_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW),
        .ECW      (ECW),
        .ERW      (ERW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rsp         (rsp),
        .eff_cols    (eff_cols),
        .eff_rows    (eff_rows),
        .text_color  (color_reg),
        .color_reset (color_reset),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wcell   (mem_wcell),
        .mem_raddr   (mem_raddr),
        .mem_rcell   (mem_rcell)
    );

    tcc_store #(
        .AW (CW + RW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wcell (mem_wcell),
        .raddr (mem_raddr),
        .rcell (mem_rcell)
    );

endmodule

// ===== design/tcc_store.sv =====
module tcc_store #(
    parameter int AW = 13
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  tcc_pkg::tcc_cell_t wcell,
    input  logic [AW-1:0]      raddr,
    output tcc_pkg::tcc_cell_t rcell
);
    import tcc_pkg::*;

    localparam int DEPTH = 2 ** AW;

    logic [CHAR_W-1:0]  char_mem  [DEPTH];
    logic [COLOR_W-1:0] color_mem [DEPTH];
    tcc_cell_t          rcell_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            char_mem[waddr]  <= wcell.ch;
            color_mem[waddr] <= wcell.color;
        end
        rcell_reg.ch    <= char_mem[raddr];
        rcell_reg.color <= color_mem[raddr];
    end

    assign rcell = rcell_reg;

endmodule

// ===== design/tcc_ctrl.sv =====
module tcc_ctrl #(
    parameter int MAX_COLS = tcc_pkg::TCC_MAX_COLS,
    parameter int MAX_ROWS = tcc_pkg::TCC_MAX_ROWS,
    parameter int CW  = $clog2(MAX_COLS),
    parameter int RW  = $clog2(MAX_ROWS),
    parameter int ECW = $clog2(MAX_COLS + 1),
    parameter int ERW = $clog2(MAX_ROWS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tcc_cmd_if.sink                     cmd,
    tcc_rsp_if.source                   rsp,
    input  logic [ECW-1:0]              eff_cols,
    input  logic [ERW-1:0]              eff_rows,
    input  logic [tcc_pkg::COLOR_W-1:0] text_color,
    output logic                        color_reset,
    output logic                        mem_we,
    output logic [CW+RW-1:0]            mem_waddr,
    output tcc_pkg::tcc_cell_t          mem_wcell,
    output logic [CW+RW-1:0]            mem_raddr,
    input  tcc_pkg::tcc_cell_t          mem_rcell
);
    import tcc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_READ_WAIT = 5'b00010,
        ST_SCROLL    = 5'b00100,
        ST_CLEAR     = 5'b01000,
        ST_FINISH    = 5'b10000
    } tcc_state_t;

    tcc_state_t state_reg, state_next;
    logic [CW-1:0] cursor_col_reg, col_next;
    logic [RW-1:0] cursor_row_reg, row_next;
    // sweep counters
    logic [RW-1:0] sr_reg, sr_next;
    logic [CW-1:0] sc_reg, sc_next;
    // copy stage of the scroll sweep
    logic               pend_valid_reg, pend_valid_next;
    logic [CW+RW-1:0]   pend_addr_reg, pend_addr_next;
    logic               pend_fill_reg, pend_fill_next;
    // result being built
    logic               res_scrolled_reg, res_scrolled_next;
    logic               res_hit_reg, res_hit_next;
    logic [CHAR_W-1:0]  res_char_reg, res_char_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    // output word
    logic               out_valid_reg;
    logic               out_load;
    logic [OCOL_W-1:0]  out_col_reg;
    logic [OROW_W-1:0]  out_row_reg;
    logic               out_scrolled_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic          accept;
    logic [ECW-1:0] col_inc;
    logic [ERW-1:0] row_inc;
    logic          wrap, at_bottom, printable, pos_ok;
    logic [RW-1:0] last_row;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign col_inc   = ECW'(cursor_col_reg) + ECW'(1);
    assign row_inc   = ERW'(cursor_row_reg) + ERW'(1);
    assign wrap      = (col_inc >= eff_cols);
    assign at_bottom = (row_inc >= eff_rows);
    assign last_row  = RW'(eff_rows - ERW'(1));
    assign printable = (cmd.char_code >= CHAR_SPACE) && (cmd.char_code <= CHAR_LAST_PRINT);
    assign pos_ok    = (int'(cmd.pos_x) < int'(eff_cols)) && (int'(cmd.pos_y) < int'(eff_rows));

    // Read address: source row during scroll, else the requested cell
    assign mem_raddr = (state_reg == ST_SCROLL) ? {RW'(sr_reg + RW'(1)), sc_reg}
                                                : {cmd.pos_y[RW-1:0], cmd.pos_x[CW-1:0]};

    // Command decode, sweeps and write port
    always_comb
    begin
        state_next        = state_reg;
        col_next          = cursor_col_reg;
        row_next          = cursor_row_reg;
        sr_next           = sr_reg;
        sc_next           = sc_reg;
        pend_valid_next   = 1'b0;
        pend_addr_next    = pend_addr_reg;
        pend_fill_next    = pend_fill_reg;
        res_scrolled_next = res_scrolled_reg;
        res_hit_next      = res_hit_reg;
        res_char_next     = res_char_reg;
        res_color_next    = res_color_reg;
        color_reset       = 1'b0;
        out_load          = 1'b0;

        // delayed copy write of the scroll sweep
        mem_we    = pend_valid_reg;
        mem_waddr = pend_addr_reg;
        mem_wcell = pend_fill_reg ? CELL_BLANK : mem_rcell;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_scrolled_next = 1'b0;
                    res_char_next     = '0;
                    res_color_next    = '0;
                    sr_next           = '0;
                    sc_next           = '0;
                    state_next        = ST_FINISH;
                    unique case (cmd.func)
                        FUNC_PUT:
                        begin
                            if (printable)
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = {cursor_row_reg, cursor_col_reg};
                                mem_wcell.ch    = cmd.char_code;
                                mem_wcell.color = text_color;
                                if (wrap)
                                begin
                                    col_next = '0;
                                    if (at_bottom)
                                    begin
                                        row_next          = last_row;
                                        res_scrolled_next = 1'b1;
                                        state_next        = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = RW'(row_inc);
                                    end
                                end
                                else
                                begin
                                    col_next = CW'(col_inc);
                                end
                            end
                            else if (cmd.char_code == CHAR_NEWLINE)
                            begin
                                if (!at_bottom)
                                begin
                                    if (int'(cursor_col_reg) < int'(eff_cols))
                                        row_next = RW'(row_inc);
                                end
                                else
                                begin
                                    row_next          = last_row;
                                    res_scrolled_next = 1'b1;
                                    state_next        = ST_SCROLL;
                                end
                            end
                            else if (cmd.char_code == CHAR_BACKSPACE)
                            begin
                                if (cursor_col_reg != '0
                                    && int'(cursor_col_reg) <= int'(eff_cols)
                                    && int'(cursor_row_reg) < int'(eff_rows))
                                    col_next = cursor_col_reg - CW'(1);
                            end
                            else if (cmd.char_code == CHAR_RETURN)
                            begin
                                if (int'(cursor_row_reg) < int'(eff_rows))
                                    col_next = '0;
                            end
                        end
                        FUNC_GOTO:
                        begin
                            if (pos_ok)
                            begin
                                col_next = cmd.pos_x[CW-1:0];
                                row_next = cmd.pos_y[RW-1:0];
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            col_next    = '0;
                            row_next    = '0;
                            color_reset = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        FUNC_READ:
                        begin
                            res_hit_next = pos_ok;
                            state_next   = ST_READ_WAIT;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                res_char_next  = res_hit_reg ? mem_rcell.ch : '0;
                res_color_next = res_hit_reg ? mem_rcell.color : '0;
                state_next     = ST_FINISH;
            end
            ST_SCROLL:
            begin
                // row sr takes row sr+1; the last row is blanked
                pend_valid_next = 1'b1;
                pend_addr_next  = {sr_reg, sc_reg};
                pend_fill_next  = (sr_reg == last_row);
                if (sc_reg == CW'(MAX_COLS - 1))
                begin
                    sc_next = '0;
                    if (sr_reg == last_row)
                        state_next = ST_FINISH;
                    else
                        sr_next = sr_reg + RW'(1);
                end
                else
                begin
                    sc_next = sc_reg + CW'(1);
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {sr_reg, sc_reg};
                mem_wcell = CELL_BLANK;
                if (sc_reg == CW'(MAX_COLS - 1))
                begin
                    sc_next = '0;
                    if (sr_reg == RW'(MAX_ROWS - 1))
                        state_next = ST_FINISH;
                    else
                        sr_next = sr_reg + RW'(1);
                end
                else
                begin
                    sc_next = sc_reg + CW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_col_reg <= col_next;
            cursor_row_reg <= row_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and counters
    always_ff @(posedge clk)
    begin
        sr_reg           <= sr_next;
        sc_reg           <= sc_next;
        pend_addr_reg    <= pend_addr_next;
        pend_fill_reg    <= pend_fill_next;
        res_scrolled_reg <= res_scrolled_next;
        res_hit_reg      <= res_hit_next;
        res_char_reg     <= res_char_next;
        res_color_reg    <= res_color_next;
        if (out_load)
        begin
            out_col_reg      <= OCOL_W'(cursor_col_reg);
            out_row_reg      <= OROW_W'(cursor_row_reg);
            out_scrolled_reg <= res_scrolled_reg;
            out_char_reg     <= res_char_reg;
            out_color_reg    <= res_color_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_column = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.scrolled      = out_scrolled_reg;
    assign rsp.cell_char     = out_char_reg;
    assign rsp.cell_color    = out_color_reg;

    // Checks
    a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCROLL || state_reg == ST_FINISH))
        else $error("copy write outside scroll");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) |-> (sr_reg <= last_row))
        else $error("scroll sweep past last row");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == FUNC_READ) |=> (state_reg == ST_READ_WAIT))
        else $error("read did not wait for store data");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == FUNC_CLEAR)
        |=> (state_reg == ST_CLEAR && cursor_col_reg == '0 && cursor_row_reg == '0))
        else $error("clear did not home cursor");

endmodule

// ===== tb/text_console_cursor_engine_top_tb.sv =====
`timescale 1ns / 1ps

module text_console_cursor_engine_top_tb;
    import tcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 50;
    localparam int PHASES         = 7;

    // One command word and one cursor report word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } console_cmd_t;

    typedef struct packed {
        logic [OCOL_W-1:0]  column;
        logic [OROW_W-1:0]  row;
        logic               scrolled;
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_color;
    } cursor_report_t;

    logic clk;
    logic rst_n;

    tcc_cmd_if cmd ();
    tcc_rsp_if rsp ();
    tcc_cfg_if cfg ();

    text_console_cursor_engine_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Geometry, color and traffic shape of each phase after the opening one
    int unsigned phase_columns [PHASES] = '{8, 1, 0, 128, 255, 13, 37};
    int unsigned phase_rows    [PHASES] = '{4, 1, 0, 64, 127, 5, 9};
    int unsigned phase_colors  [PHASES] = '{8'h1e, 8'hff, 8'h00, 8'ha5, 8'h5a, 8'hc3, 8'h3c};
    int unsigned phase_items   [PHASES] = '{200, 60, 60, 40, 30, 200, 140};
    int unsigned phase_mode    [PHASES] = '{1, 2, 3, 0, 2, 3, 1};
    int unsigned mode_send_gap [4]      = '{0, 71, 0, 28};
    int unsigned mode_stall    [4]      = '{0, 0, 71, 28};

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    console_cmd_t   pending_commands [$];
    cursor_report_t awaited_reports  [$];

    // Shadow of the screen, cursor and registers
    logic [CHAR_W-1:0]  shadow_char  [TCC_MAX_ROWS][TCC_MAX_COLS];
    logic [COLOR_W-1:0] shadow_color [TCC_MAX_ROWS][TCC_MAX_COLS];
    int unsigned        cursor_x;
    int unsigned        cursor_y;
    logic [COLS_W-1:0]  columns_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [COLOR_W-1:0] color_reg;

    int commands_accepted = 0;
    int results_seen      = 0;
    int scroll_count      = 0;
    int clear_count       = 0;
    int reads_in_range    = 0;
    int register_writes   = 0;
    int mismatch_count    = 0;
    int idle_cycles       = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Register value as the block uses it: zero counts as one, large values saturate
    function automatic int unsigned span_limit(input int unsigned raw, input int unsigned cap);
        if (raw == 0)
            return 1;
        return (raw > cap) ? cap : raw;
    endfunction

    // Cursor moves only to a cell inside the visible screen
    function automatic void place_cursor(input int unsigned x, input int unsigned y);
        if (x < span_limit(columns_reg, TCC_MAX_COLS) && y < span_limit(rows_reg, TCC_MAX_ROWS))
        begin
            cursor_x = x;
            cursor_y = y;
        end
    endfunction

    // Rows move up one; the last row in use is blanked over the full store width
    function automatic void scroll_shadow();
        int unsigned last;
        last = span_limit(rows_reg, TCC_MAX_ROWS) - 1;
        for (int r = 0; r < int'(last); r++)
        begin
            for (int c = 0; c < TCC_MAX_COLS; c++)
            begin
                shadow_char[r][c]  = shadow_char[r + 1][c];
                shadow_color[r][c] = shadow_color[r + 1][c];
            end
        end
        for (int c = 0; c < TCC_MAX_COLS; c++)
        begin
            shadow_char[last][c]  = CHAR_SPACE;
            shadow_color[last][c] = COLOR_BLANK;
        end
        scroll_count++;
    endfunction

    // Screen update for one command; returns the report the block should give
    function automatic cursor_report_t apply_console_command(input console_cmd_t c);
        cursor_report_t rep;
        int unsigned    cols;
        int unsigned    rows;
        cols = span_limit(columns_reg, TCC_MAX_COLS);
        rows = span_limit(rows_reg, TCC_MAX_ROWS);
        rep  = '0;
        case (c.func)
            FUNC_PUT:
            begin
                if (c.char_code >= CHAR_SPACE && c.char_code <= CHAR_LAST_PRINT)
                begin
                    shadow_char[cursor_y][cursor_x]  = c.char_code;
                    shadow_color[cursor_y][cursor_x] = color_reg;
                    if (cursor_x + 1 >= cols)
                    begin
                        cursor_x = 0;
                        if (cursor_y + 1 >= rows)
                        begin
                            scroll_shadow();
                            rep.scrolled = 1'b1;
                            cursor_y     = rows - 1;
                        end
                        else
                            cursor_y++;
                    end
                    else
                        cursor_x++;
                end
                else if (c.char_code == CHAR_NEWLINE)
                begin
                    // At the bottom the column is kept and the screen scrolls
                    if (cursor_y + 1 < rows)
                        place_cursor(cursor_x, cursor_y + 1);
                    else
                    begin
                        scroll_shadow();
                        rep.scrolled = 1'b1;
                        cursor_y     = rows - 1;
                    end
                end
                else if (c.char_code == CHAR_BACKSPACE)
                begin
                    if (cursor_x > 0)
                        place_cursor(cursor_x - 1, cursor_y);
                end
                else if (c.char_code == CHAR_RETURN)
                    place_cursor(0, cursor_y);
            end
            FUNC_GOTO:
                place_cursor(c.pos_x, c.pos_y);
            FUNC_CLEAR:
            begin
                for (int r = 0; r < TCC_MAX_ROWS; r++)
                begin
                    for (int k = 0; k < TCC_MAX_COLS; k++)
                    begin
                        shadow_char[r][k]  = CHAR_SPACE;
                        shadow_color[r][k] = COLOR_BLANK;
                    end
                end
                cursor_x  = 0;
                cursor_y  = 0;
                color_reg = COLOR_BLANK;
                clear_count++;
            end
            default:
            begin
                if (c.pos_x < cols && c.pos_y < rows)
                begin
                    rep.cell_char  = shadow_char[c.pos_y][c.pos_x];
                    rep.cell_color = shadow_color[c.pos_y][c.pos_x];
                    reads_in_range++;
                end
            end
        endcase
        rep.column = OCOL_W'(cursor_x);
        rep.row    = OROW_W'(cursor_y);
        return rep;
    endfunction

    // Mostly text with control codes, cursor moves and reads inside the screen; some off-screen moves, reads and clears
    function automatic console_cmd_t random_console_command(input int unsigned cols,
                                                            input int unsigned rows);
        console_cmd_t c;
        int unsigned  pick;
        pick        = $urandom_range(999);
        c.func      = FUNC_PUT;
        c.char_code = CHAR_W'($urandom);
        c.pos_x     = POS_W'($urandom);
        c.pos_y     = POS_W'($urandom);
        if (pick < 560)
            c.char_code = CHAR_W'($urandom_range(127, 32));
        else if (pick < 640)
            c.char_code = CHAR_NEWLINE;
        else if (pick < 690)
            c.char_code = CHAR_BACKSPACE;
        else if (pick < 720)
            c.char_code = CHAR_RETURN;
        else if (pick < 760)
            c.func = FUNC_PUT;   // any code, mostly ignored ones
        else if (pick < 830)
        begin
            c.func  = FUNC_GOTO;
            c.pos_x = POS_W'($urandom_range(cols - 1));
            c.pos_y = POS_W'($urandom_range(rows - 1));
        end
        else if (pick < 850)
            c.func = FUNC_GOTO;  // anywhere, usually off screen
        else if (pick < 960)
        begin
            c.func  = FUNC_READ;
            c.pos_x = POS_W'($urandom_range(cols - 1));
            c.pos_y = POS_W'($urandom_range(rows - 1));
        end
        else if (pick < 990)
            c.func = FUNC_READ;
        else
            c.func = FUNC_CLEAR;
        return c;
    endfunction

    task automatic queue_command(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                                 input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        pending_commands.push_back({func, ch, x, y});
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_commands.size() != 0 || cmd.valid || awaited_reports.size() != 0);
    endtask

    // Command driver and result receiver readiness
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd.valid     <= 1'b0;
            cmd.func      <= FUNC_PUT;
            cmd.char_code <= '0;
            cmd.pos_x     <= '0;
            cmd.pos_y     <= '0;
            rsp.ready     <= 1'b0;
        end
        else
        begin
            if (!cmd.valid || cmd.ready)
            begin
                if (pending_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    cmd.valid <= 1'b1;
                    {cmd.func, cmd.char_code, cmd.pos_x, cmd.pos_y} <= pending_commands.pop_front();
                end
                else
                    cmd.valid <= 1'b0;
            end
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: follow register writes, predict on each command, check each result
    always @(posedge clk)
    begin : console_monitor
        cursor_report_t want;
        if (!rst_n)
        begin
            cursor_x    = 0;
            cursor_y    = 0;
            columns_reg = COLS_RESET;
            rows_reg    = ROWS_RESET;
            color_reg   = COLOR_BLANK;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                register_writes++;
                case (cfg.index)
                    REG_COLUMNS: columns_reg = cfg.data;
                    REG_ROWS:    rows_reg    = cfg.data[ROWS_W-1:0];
                    REG_COLOR:   color_reg   = cfg.data;
                    default:     ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                commands_accepted++;
                awaited_reports.push_back(
                    apply_console_command({cmd.func, cmd.char_code, cmd.pos_x, cmd.pos_y}));
            end
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (awaited_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result %0d arrived with none outstanding", results_seen);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (rsp.cursor_column !== want.column || rsp.cursor_row !== want.row ||
                        rsp.scrolled !== want.scrolled || rsp.cell_char !== want.cell_char ||
                        rsp.cell_color !== want.cell_color)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"result %0d: expected col %0d row %0d scr %0d ch %02h ",
                                      "attr %02h, got col %0d row %0d scr %0d ch %02h attr %02h"},
                                     results_seen, want.column, want.row, want.scrolled,
                                     want.cell_char, want.cell_color, rsp.cursor_column,
                                     rsp.cursor_row, rsp.scrolled, rsp.cell_char,
                                     rsp.cell_color);
                    end
                end
            end
        end
    end

    // Watchdog on cycles where no word moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned cols;
        int unsigned rows;
        cfg.valid     = 1'b0;
        cfg.index     = REG_COLUMNS;
        cfg.data      = '0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Opening sequence at the reset geometry; the store is cleared before any read
        queue_command(FUNC_CLEAR, 8'h00, 8'd0, 8'd0);
        queue_command(FUNC_READ, 8'h00, 8'd0, 8'd0);
        queue_command(FUNC_PUT, 8'h41, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_SPACE, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_LAST_PRINT, 8'd0, 8'd0);
        queue_command(FUNC_PUT, 8'h1f, 8'd0, 8'd0);
        queue_command(FUNC_PUT, 8'h80, 8'd0, 8'd0);
        queue_command(FUNC_PUT, 8'hff, 8'd0, 8'd0);
        queue_command(FUNC_PUT, 8'h00, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_BACKSPACE, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_RETURN, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_BACKSPACE, 8'd0, 8'd0);  // at column zero: no move
        queue_command(FUNC_READ, 8'h00, 8'd1, 8'd0);
        queue_command(FUNC_GOTO, 8'h00, 8'd79, 8'd29);        // last visible cell
        queue_command(FUNC_PUT, 8'h5a, 8'd0, 8'd0);           // wrap plus scroll
        queue_command(FUNC_PUT, 8'h71, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_NEWLINE, 8'd0, 8'd0);    // bottom row: scroll, keep column
        queue_command(FUNC_GOTO, 8'h00, 8'd80, 8'd0);
        queue_command(FUNC_GOTO, 8'h00, 8'd0, 8'd30);
        queue_command(FUNC_GOTO, 8'h00, 8'd255, 8'd255);
        queue_command(FUNC_READ, 8'h00, 8'd79, 8'd27);
        queue_command(FUNC_READ, 8'h00, 8'd0, 8'd28);
        queue_command(FUNC_READ, 8'h00, 8'd80, 8'd0);
        queue_command(FUNC_READ, 8'h00, 8'd0, 8'd255);
        queue_command(FUNC_GOTO, 8'h00, 8'd0, 8'd0);
        queue_command(FUNC_PUT, CHAR_NEWLINE, 8'd0, 8'd0);
        for (int i = 0; i < 120; i++)
            pending_commands.push_back(random_console_command(COLS_RESET, ROWS_RESET));
        wait_until_drained();

        // Random phases, each with its own geometry and traffic shape
        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_COLUMNS, CFG_DATA_W'(phase_columns[p]));
            write_register(REG_ROWS, CFG_DATA_W'(phase_rows[p]));
            write_register(REG_COLOR, CFG_DATA_W'(phase_colors[p]));
            @(negedge clk);
            sender_idle_pct    = mode_send_gap[phase_mode[p]];
            receiver_stall_pct = mode_stall[phase_mode[p]];
            cols = span_limit(phase_columns[p], TCC_MAX_COLS);
            rows = span_limit(phase_rows[p], TCC_MAX_ROWS);
            for (int i = 0; i < int'(phase_items[p]); i++)
                pending_commands.push_back(random_console_command(cols, rows));
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_reports.size() != 0)
            mismatch_count++;
        $display({"%0d commands over %0d register writes: %0d scrolls, %0d clears, ",
                  "%0d reads on screen"},
                 commands_accepted, register_writes, scroll_count, clear_count, reads_in_range);
        $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
